/* rtl/core/round_robin_soft_timer_slots_macros.svh */
// Assertion helpers for the timer slot pool.
// Every check samples on clk and is masked while rst_n is low.
`ifndef ROUND_ROBIN_SOFT_TIMER_SLOTS_MACROS_SVH
`define ROUND_ROBIN_SOFT_TIMER_SLOTS_MACROS_SVH

// Condition must hold at every clock edge out of reset.
`define RRST_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RRST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RRST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/rrst_pkg.sv */
package rrst_pkg;

  // Default pool geometry
  localparam int SLOTS_DEF       = 32;
  localparam int PERIOD_BITS_DEF = 16;

  // Item field widths
  localparam int ACTION_W   = 2;
  localparam int PERIOD_W   = 16;
  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  // Item kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK = 2'd0,
    ACT_ADD  = 2'd1,
    ACT_DEL  = 2'd2,
    ACT_NOP  = 2'd3
  } act_t;

endpackage

/* rtl/core/rrst_ram.sv */
module rrst_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, write-first on an address match
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/rrst_free_enc.sv */
module rrst_free_enc #(
  parameter int SLOTS = 32,
  parameter int IW    = $clog2(SLOTS)
) (
  input  logic [SLOTS-1:0] used,
  output logic             found,
  output logic [IW-1:0]    idx
);

  // Pick the lowest free slot; scan from the top so the lowest wins
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        found = 1'b1;
        idx   = IW'(i);
      end
    end
  end

endmodule

/* rtl/core/round_robin_soft_timer_slots.sv */
// Each accepted item is held in the input register and, once the result register is free, completes into it.
// Throughput: one item per cycle while the output is not stalled; the link and count stores are read at
// acceptance with write-first forwarding, so each item sees its predecessor.
// Reset: synchronous, active low; clears slot-used bits, count, head, tail, cur
// pointer and both handshakes. Link, reload and count stores are not cleared.
`include "round_robin_soft_timer_slots_macros.svh"

module round_robin_soft_timer_slots #(
  parameter int SLOTS       = rrst_pkg::SLOTS_DEF,
  parameter int PERIOD_BITS = rrst_pkg::PERIOD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // period [15:0], slot [20:16], zero [23:21]
  input  logic [rrst_pkg::IN_DATA_W-1:0]  in_tdata,
  // action [1:0]
  input  logic [rrst_pkg::ACTION_W-1:0]   in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // fired [0], fired_slot [5:1], added [6], added_slot [11:7],
  // active_count [17:12], zero [23:18]
  output logic [rrst_pkg::OUT_DATA_W-1:0] out_tdata
);

  import rrst_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // Input register
  logic                   in_valid_r;
  act_t                   act_r;
  logic [PERIOD_BITS-1:0] period_r;
  logic [IW-1:0]          sidx_r;
  logic                   srange_r;

  // Pool state
  logic [SLOTS-1:0] used_r, used_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    head_r, head_nxt;
  logic [IW-1:0]    tail_r, tail_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;

  // Result register
  logic               out_valid_r;
  logic               fired_r, added_r;
  logic [SLOT_W-1:0]  fslot_r, aslot_r;
  logic [COUNT_W-1:0] acount_r;

  // Store ports
  logic                   nl_we, pl_we, rl_we, rm_we;
  logic [IW-1:0]          nl_wa, pl_wa, rl_wa, rm_wa;
  logic [IW-1:0]          nl_wd, pl_wd, nl_rd, pl_rd;
  logic [PERIOD_BITS-1:0] rl_wd, rm_wd, rl_rd, rm_rd;
  logic [IW-1:0]          nl_ra, cur_eff;

  // Per-item results
  logic          fire, add_ok;
  logic [IW-1:0] fidx;
  logic          free_found;
  logic [IW-1:0] free_idx;
  logic          del_head, del_tail;
  logic [IW-1:0] del_n, head_after;

  // Handshake
  logic  commit, in_acc;
  act_t  in_act;
  logic [SLOT_W-1:0] in_slot;
  logic [IW-1:0]     in_sidx;

  assign commit    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || commit;
  assign in_acc    = in_tvalid && in_tready;
  assign in_act    = act_t'(in_tuser);
  assign in_slot   = in_tdata[PERIOD_W +: SLOT_W];
  assign in_sidx   = IW'(in_slot);

  rrst_free_enc #(.SLOTS(SLOTS), .IW(IW)) u_free (
    .used  (used_r),
    .found (free_found),
    .idx   (free_idx)
  );

  // Next pool state and store writes for the item in the input register
  always_comb begin
    used_nxt   = used_r;
    count_nxt  = count_r;
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    cur_nxt    = cur_r;
    nl_we      = 1'b0;
    nl_wa      = tail_r;
    nl_wd      = free_idx;
    pl_we      = 1'b0;
    pl_wa      = free_idx;
    pl_wd      = tail_r;
    rl_we      = 1'b0;
    rl_wa      = free_idx;
    rl_wd      = period_r;
    rm_we      = 1'b0;
    rm_wa      = cur_r;
    rm_wd      = period_r;
    fire       = 1'b0;
    fidx       = cur_r;
    add_ok     = 1'b0;
    del_head   = (sidx_r == head_r);
    del_tail   = (sidx_r == tail_r);
    del_n      = nl_rd;
    head_after = del_head ? nl_rd : head_r;
    if (in_valid_r) begin
      case (act_r)
        ACT_TICK: begin
          // Drop the current count by the pool size, fire and reload at or past zero, then advance the pointer
          if (count_r != '0) begin
            rm_we = 1'b1;
            rm_wa = cur_r;
            if (rm_rd <= count_r) begin
              fire  = 1'b1;
              rm_wd = rl_rd;
            end else begin
              rm_wd = rm_rd - PERIOD_BITS'(count_r);
            end
            cur_nxt = (cur_r == tail_r) ? head_r : nl_rd;
          end
        end
        ACT_ADD: begin
          // Take the lowest free slot and append it at the tail
          if (free_found) begin
            add_ok             = 1'b1;
            used_nxt[free_idx] = 1'b1;
            count_nxt          = count_r + CW'(1);
            rl_we              = 1'b1;
            rm_we              = 1'b1;
            rm_wa              = free_idx;
            tail_nxt           = free_idx;
            if (count_r == '0) begin
              head_nxt = free_idx;
              cur_nxt  = free_idx;
            end else begin
              nl_we = 1'b1;
              pl_we = 1'b1;
            end
          end
        end
        ACT_DEL: begin
          // Unlink a used slot and repair head, tail and pointer
          if (srange_r && used_r[sidx_r]) begin
            used_nxt[sidx_r] = 1'b0;
            count_nxt        = count_r - CW'(1);
            if (del_head) begin
              head_nxt = del_n;
            end else begin
              nl_we = 1'b1;
              nl_wa = pl_rd;
              nl_wd = del_n;
            end
            if (del_tail) begin
              tail_nxt = pl_rd;
            end else begin
              pl_we = 1'b1;
              pl_wa = del_n;
              pl_wd = pl_rd;
            end
            if (cur_r == sidx_r) begin
              cur_nxt = del_tail ? head_after : del_n;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Read addresses follow the state this item will see
  assign cur_eff = commit ? cur_nxt : cur_r;
  assign nl_ra   = (in_act == ACT_DEL) ? in_sidx : cur_eff;

  rrst_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_next (
    .clk (clk), .we (commit && nl_we), .waddr (nl_wa), .wdata (nl_wd),
    .re (in_acc), .raddr (nl_ra), .rdata (nl_rd)
  );

  rrst_ram #(.DEPTH(SLOTS), .WIDTH(IW)) u_prev (
    .clk (clk), .we (commit && pl_we), .waddr (pl_wa), .wdata (pl_wd),
    .re (in_acc), .raddr (in_sidx), .rdata (pl_rd)
  );

  rrst_ram #(.DEPTH(SLOTS), .WIDTH(PERIOD_BITS)) u_reload (
    .clk (clk), .we (commit && rl_we), .waddr (rl_wa), .wdata (rl_wd),
    .re (in_acc), .raddr (cur_eff), .rdata (rl_rd)
  );

  rrst_ram #(.DEPTH(SLOTS), .WIDTH(PERIOD_BITS)) u_remain (
    .clk (clk), .we (commit && rm_we), .waddr (rm_wa), .wdata (rm_wd),
    .re (in_acc), .raddr (cur_eff), .rdata (rm_rd)
  );

  // Capture an accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r    <= in_act;
      period_r <= PERIOD_BITS'(in_tdata[PERIOD_W-1:0]);
      sidx_r   <= in_sidx;
      srange_r <= (32'(in_slot) < SLOTS);
    end
  end

  // Update pool state when an item completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= '0;
      count_r <= '0;
      head_r  <= '0;
      tail_r  <= '0;
      cur_r   <= '0;
    end else if (commit) begin
      used_r  <= used_nxt;
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cur_r   <= cur_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      fired_r  <= fire;
      fslot_r  <= fire ? SLOT_W'(fidx) : '0;
      added_r  <= add_ok;
      aslot_r  <= add_ok ? SLOT_W'(free_idx) : '0;
      acount_r <= COUNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - 2 * SLOT_W - COUNT_W - 2)'(0),
                       acount_r, aslot_r, added_r, fslot_r, fired_r};

  // Checks
  `RRST_ASSERT_ALWAYS(a_count_matches_used, $countones(used_r) == 32'(count_r),
    "slot count disagrees with used bits")
  `RRST_ASSERT_IMPL(a_stall_only_on_full_output, !in_tready,
    in_valid_r && out_valid_r && !out_tready, "input stalled without output backpressure")
  `RRST_ASSERT_IMPL(a_fire_needs_slots, commit && fire, count_r != '0,
    "slot fired from an empty pool")
  `RRST_ASSERT_NEXT(a_commit_shows_result, commit, out_valid_r,
    "completed item produced no result")

endmodule

/* tb/round_robin_soft_timer_slots_tb.sv */
`timescale 1ns / 100ps

module round_robin_soft_timer_slots_tb;
  import rrst_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [5:0] NIL = 6'(SLOTS);
  localparam int STALL_LIMIT = 2000;

  // One result item, MSB first so that it overlays out_tdata[17:0]
  typedef struct packed {
    logic [COUNT_W-1:0] active_count;
    logic [SLOT_W-1:0]  added_slot;
    logic               added;
    logic [SLOT_W-1:0]  fired_slot;
    logic               fired;
  } timer_result_t;

  typedef enum {TRAFFIC_GROW, TRAFFIC_STEADY, TRAFFIC_SHRINK} traffic_mode_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [ACTION_W-1:0]   in_tuser = ACT_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // Timer pool as the block should hold it
  bit          pool_used   [SLOTS];
  logic [15:0] pool_reload [SLOTS];
  logic [17:0] pool_left   [SLOTS];
  logic [5:0]  pool_next   [SLOTS];
  logic [5:0]  pool_prev   [SLOTS];
  logic [5:0]  pool_head  = NIL;
  logic [5:0]  pool_tail  = NIL;
  logic [5:0]  pool_cur   = NIL;
  logic [5:0]  pool_count = '0;

  timer_result_t pending_results[$];
  timer_result_t seen_result;
  timer_result_t want_result;
  int            mismatch_count = 0;
  int            idle_cycles = 0;
  int            burst_left = 0;
  int            rx_phase_left = 0;
  int            rx_stall_pct = 0;

  round_robin_soft_timer_slots uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Apply one item to the pool and return the result it should produce
  function automatic timer_result_t timer_pool_step(act_t act, logic [15:0] period,
                                                    logic [4:0] sidx);
    timer_result_t r;
    int            free_idx;
    logic [5:0]    c;
    logic [5:0]    p;
    logic [5:0]    n;
    logic [5:0]    s;
    r = '0;
    case (act)
      ACT_TICK: begin
        c = pool_cur;
        if (pool_count != 0 && c < NIL) begin
          // fire and reload when the drop reaches or passes zero
          if (pool_left[c] <= {12'd0, pool_count}) begin
            r.fired      = 1'b1;
            r.fired_slot = c[4:0];
            pool_left[c] = {2'b00, pool_reload[c]};
          end else begin
            pool_left[c] = pool_left[c] - {12'd0, pool_count};
          end
          pool_cur = pool_next[c];
          if (pool_cur >= NIL) pool_cur = pool_head;
        end
      end
      ACT_ADD: begin
        free_idx = SLOTS;
        for (int i = SLOTS - 1; i >= 0; i--) begin
          if (!pool_used[i]) free_idx = i;
        end
        if (free_idx < SLOTS) begin
          pool_used[free_idx]   = 1'b1;
          pool_count            = pool_count + 6'd1;
          pool_reload[free_idx] = period;
          pool_left[free_idx]   = {2'b00, period};
          pool_next[free_idx]   = NIL;
          // append at the tail, or start the list
          if (pool_head >= NIL) begin
            pool_prev[free_idx] = NIL;
            pool_head = 6'(free_idx);
            pool_tail = 6'(free_idx);
            pool_cur  = 6'(free_idx);
          end else begin
            pool_prev[free_idx]  = pool_tail;
            pool_next[pool_tail] = 6'(free_idx);
            pool_tail = 6'(free_idx);
          end
          r.added      = 1'b1;
          r.added_slot = free_idx[4:0];
        end
      end
      ACT_DEL: begin
        s = {1'b0, sidx};
        if (s < NIL && pool_used[s]) begin
          pool_used[s] = 1'b0;
          pool_count   = pool_count - 6'd1;
          p = pool_prev[s];
          n = pool_next[s];
          // unlink
          if (p >= NIL) pool_head = n;
          else pool_next[p] = n;
          if (n >= NIL) pool_tail = p;
          else pool_prev[n] = p;
          // a deleted current slot hands over to its successor, else the head
          if (pool_cur == s) pool_cur = (n < NIL) ? n : pool_head;
          if (pool_count == 0) begin
            pool_head = NIL;
            pool_tail = NIL;
            pool_cur  = NIL;
          end
        end
      end
      default: begin
      end
    endcase
    r.active_count = pool_count;
    return r;
  endfunction

  // Pick a used slot at random, starting the search from a random index
  function automatic logic [4:0] pick_used_slot();
    int start;
    int idx;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      idx = (start + k) % SLOTS;
      if (pool_used[idx]) return idx[4:0];
    end
    return start[4:0];
  endfunction

  // Send one item, opening a new burst after a random gap when the last one ran out
  task automatic send_item(act_t act, logic [15:0] period, logic [4:0] sidx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, sidx, period};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(timer_pool_step(act, period, sidx));
    burst_left--;
  endtask

  task automatic send_tick();
    send_item(ACT_TICK, 16'($urandom_range(0, 65535)), 5'($urandom_range(0, 31)));
  endtask

  task automatic note_mismatch(string field, int expv, int gotv);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %0d, got %0d", field, expv, gotv);
  endtask

  // Empty pool, no-op action, period extremes, deletes of free and current slots
  task automatic test_directed_corners();
    send_item(ACT_TICK, 16'h0000, 5'd0);
    send_item(ACT_NOP, 16'hFFFF, 5'd31);
    send_item(ACT_DEL, 16'h1234, 5'd0);
    send_item(ACT_DEL, 16'h0000, 5'd31);
    send_item(ACT_ADD, 16'h0000, 5'd0);
    send_tick();
    send_tick();
    send_item(ACT_ADD, 16'hFFFF, 5'd31);
    send_item(ACT_ADD, 16'd1, 5'd0);
    send_item(ACT_ADD, 16'd5, 5'd0);
    repeat (6) send_tick();
    send_item(ACT_NOP, 16'h0000, 5'd0);
    // delete the current slot away from the tail
    while (pool_cur == pool_tail) send_tick();
    send_item(ACT_DEL, 16'h0000, pool_cur[4:0]);
    // delete the current slot at the tail
    while (pool_cur != pool_tail) send_tick();
    send_item(ACT_DEL, 16'h0000, pool_tail[4:0]);
    for (int i = 0; i < SLOTS; i++) begin
      if (pool_used[i]) send_item(ACT_DEL, 16'hFFFF, 5'(i));
    end
    send_tick();
  endtask

  // Fill every slot, overflow, reuse freed slots, then drain
  task automatic test_pool_full();
    for (int i = 0; i < SLOTS; i++)
      send_item(ACT_ADD, 16'($urandom_range(0, 40)), 5'($urandom_range(0, 31)));
    send_item(ACT_ADD, 16'hFFFF, 5'd31);
    repeat (40) send_tick();
    repeat (4) send_item(ACT_DEL, 16'h0000, 5'($urandom_range(0, 31)));
    repeat (3) send_item(ACT_ADD, 16'($urandom_range(0, 20)), 5'd0);
    repeat (20) send_tick();
    while (pool_count != 0) send_item(ACT_DEL, 16'h0000, pick_used_slot());
  endtask

  // Rounds of mixed traffic that grow, hold or shrink the pool
  task automatic test_random_traffic();
    traffic_mode_t mode;
    int            roll;
    int            add_pct;
    int            del_pct;
    logic [15:0]   period;
    logic [4:0]    sidx;
    for (int round = 0; round < 8; round++) begin
      mode = traffic_mode_t'($urandom_range(0, 2));
      add_pct = (mode == TRAFFIC_GROW) ? 45 : (mode == TRAFFIC_SHRINK) ? 10 : 20;
      del_pct = (mode == TRAFFIC_SHRINK) ? 40 : (mode == TRAFFIC_GROW) ? 8 : 15;
      repeat (50) begin
        roll = $urandom_range(0, 99);
        period = 16'($urandom_range(0, 65535));
        sidx = 5'($urandom_range(0, 31));
        if (roll < add_pct) begin
          // mostly short periods so that slots fire often
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: period = 16'($urandom_range(0, 48));
            7, 8: ;
            default: begin
              case ($urandom_range(0, 3))
                0: period = 16'h0000;
                1: period = 16'h0001;
                2: period = 16'h8000;
                default: period = 16'hFFFF;
              endcase
            end
          endcase
          send_item(ACT_ADD, period, sidx);
        end else if (roll < add_pct + del_pct) begin
          if ($urandom_range(0, 99) < 85) sidx = pick_used_slot();
          send_item(ACT_DEL, period, sidx);
        end else if (roll < add_pct + del_pct + 4) begin
          send_item(ACT_NOP, period, sidx);
        end else begin
          send_item(ACT_TICK, period, sidx);
        end
      end
    end
  endtask

  // Receiver: phases of random length, each with its own stall rate
  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_phase_left = $urandom_range(16, 96);
      case ($urandom_range(0, 3))
        0: rx_stall_pct = 0;
        1: rx_stall_pct = 20;
        2: rx_stall_pct = 50;
        default: rx_stall_pct = 80;
      endcase
    end
    rx_phase_left--;
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Compare each result item with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen_result = out_tdata[17:0];
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected item", 0, int'(out_tdata));
      end else begin
        want_result = pending_results.pop_front();
        if (seen_result.fired != want_result.fired)
          note_mismatch("fired", want_result.fired, seen_result.fired);
        if (seen_result.fired_slot != want_result.fired_slot)
          note_mismatch("fired_slot", want_result.fired_slot, seen_result.fired_slot);
        if (seen_result.added != want_result.added)
          note_mismatch("added", want_result.added, seen_result.added);
        if (seen_result.added_slot != want_result.added_slot)
          note_mismatch("added_slot", want_result.added_slot, seen_result.added_slot);
        if (seen_result.active_count != want_result.active_count)
          note_mismatch("active_count", want_result.active_count,
                        seen_result.active_count);
        if (out_tdata[23:18] != '0)
          note_mismatch("padding", 0, int'(out_tdata[23:18]));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_pool_full();
    test_random_traffic();
    @(negedge clk);
    in_tvalid <= 1'b0;
    // drain the expected results before the verdict
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
